@@ sv/stoch_pkg.sv @@
// ----------------------------------------------------------------------------
// stoch_pkg
// Shared types and constants for the stochastic oscillator core.
// ----------------------------------------------------------------------------
package stoch_pkg;

  localparam int MAX_K_PERIOD = 64;
  localparam int MAX_D_PERIOD = 16;
  localparam int PRICE_W      = 32;
  localparam int KP_W         = 7;
  localparam int DP_W         = 5;
  localparam int PCT_W        = 23;
  localparam int SLOT_W       = $clog2(MAX_K_PERIOD);
  localparam int HSLOT_W      = $clog2(MAX_D_PERIOD);
  localparam int SEEN_W       = 7;
  localparam int SEEN_MAX     = MAX_K_PERIOD + MAX_D_PERIOD;
  localparam int SUM_W        = 27;
  localparam int RNG_W        = PRICE_W + 1;
  localparam int REM_W        = RNG_W + 1;
  localparam int PROD_W       = RNG_W + 7;
  localparam int DIV_BITS     = SUM_W;
  localparam int DCNT_W       = $clog2(DIV_BITS + 1);
  localparam int K_QUO_BITS   = 23;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;

  localparam logic [PCT_W-1:0] PCT_SCALE = 23'd6553600;
  localparam logic [PCT_W-1:0] PCT_HALF  = 23'd3276800;

  localparam logic [CFG_IDX_W-1:0] CFG_K_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_D_PERIOD = 1'd1;

  typedef struct packed {
    logic                      first_bar;
    logic signed [PRICE_W-1:0] bar_high;
    logic signed [PRICE_W-1:0] bar_low;
    logic signed [PRICE_W-1:0] bar_close;
  } bar_t;

  typedef struct packed {
    logic             k_valid;
    logic [PCT_W-1:0] percent_k;
    logic             d_valid;
    logic [PCT_W-1:0] percent_d;
  } result_t;

  typedef struct packed {
    logic [REM_W-1:0]    rem_init;
    logic [DIV_BITS-1:0] bits;
    logic [DCNT_W-1:0]   count;
    logic [REM_W-1:0]    divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_RATIO,
    ST_KDIV,
    ST_KSTORE,
    ST_SUM,
    ST_DDIV,
    ST_OUT
  } state_t;

endpackage

@@ sv/stochastic_oscillator_core.sv @@
// Stochastic oscillator: one result request (%K, %D) per bar request. In the
// execution side a bar runs the high/low window scan through the window
// memory read port, then the shared one-bit-per-cycle divider does the %K
// ratio and the %D mean. Bars whose %K or %D is not yet valid skip the
// matching divide, and a saturated or flat %K also skips the ratio divide.
// A two-entry queue takes bars while the execution side is busy, and a
// result register lets the next bar start while a result waits.
// ----------------------------------------------------------------------------
// stochastic_oscillator_core
// Top level: configuration registers, input queue and execution side.
// ----------------------------------------------------------------------------
module stochastic_oscillator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [stoch_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stoch_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  stoch_pkg::bar_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output stoch_pkg::result_t                  out_data
);

  logic [stoch_pkg::KP_W-1:0] k_period;
  logic [stoch_pkg::DP_W-1:0] d_period;
  logic                       q_valid;
  logic                       q_ready;
  stoch_pkg::bar_t            q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_period <= stoch_pkg::KP_W'(14);
      d_period <= stoch_pkg::DP_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        stoch_pkg::CFG_K_PERIOD: k_period <= cfg_data[stoch_pkg::KP_W-1:0];
        stoch_pkg::CFG_D_PERIOD: d_period <= cfg_data[stoch_pkg::DP_W-1:0];
        default: ;
      endcase
    end
  end

  stoch_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  stoch_back u_back (
    .clk       (clk),
    .rst       (rst),
    .k_period  (k_period),
    .d_period  (d_period),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/stoch_front.sv @@
// ----------------------------------------------------------------------------
// stoch_front
// Input side: takes bar requests and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module stoch_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  stoch_pkg::bar_t in_data,
  output logic            q_valid,
  input  logic            q_ready,
  output stoch_pkg::bar_t q_data
);

  stoch_pkg::bar_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_data   = entry[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/stoch_div.sv @@
// ----------------------------------------------------------------------------
// stoch_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stoch_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  stoch_pkg::div_req_t              req,
  output logic                             done,
  output logic [stoch_pkg::DIV_BITS-1:0]   quotient
);

  logic [stoch_pkg::REM_W-1:0]    rem;
  logic [stoch_pkg::DIV_BITS-1:0] sh;
  logic [stoch_pkg::DCNT_W-1:0]   cnt;
  logic [stoch_pkg::REM_W-1:0]    divisor;
  logic                           busy;
  logic [stoch_pkg::REM_W-1:0]    trial;

  // remainder stays below the divisor, so its top bit is free for the shift
  assign trial = {rem[stoch_pkg::REM_W-2:0], sh[stoch_pkg::DIV_BITS-1]};

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= req.rem_init;
      sh       <= req.bits;
      cnt      <= req.count;
      divisor  <= req.divisor;
      quotient <= '0;
    end else if (busy) begin
      sh  <= {sh[stoch_pkg::DIV_BITS-2:0], 1'b0};
      cnt <= cnt - stoch_pkg::DCNT_W'(1);
      if (trial >= divisor) begin
        rem      <= trial - divisor;
        quotient <= {quotient[stoch_pkg::DIV_BITS-2:0], 1'b1};
      end else begin
        rem      <= trial;
        quotient <= {quotient[stoch_pkg::DIV_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == stoch_pkg::DCNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ sv/stoch_back.sv @@
// ----------------------------------------------------------------------------
// stoch_back
// Execution side: window store, high/low scan, %K and %D computation.
// ----------------------------------------------------------------------------
module stoch_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [stoch_pkg::KP_W-1:0]    k_period,
  input  logic [stoch_pkg::DP_W-1:0]    d_period,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  stoch_pkg::bar_t               q_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output stoch_pkg::result_t            out_data
);

  localparam int PW = stoch_pkg::PRICE_W;

  stoch_pkg::state_t state;
  stoch_pkg::state_t state_next;

  logic signed [PW-1:0] high_mem [stoch_pkg::MAX_K_PERIOD];
  logic signed [PW-1:0] low_mem  [stoch_pkg::MAX_K_PERIOD];
  logic signed [PW-1:0] high_q;
  logic signed [PW-1:0] low_q;
  logic [stoch_pkg::PCT_W-1:0] hist [stoch_pkg::MAX_D_PERIOD];

  stoch_pkg::bar_t                 bar;
  logic [stoch_pkg::SLOT_W-1:0]    bar_slot;
  logic [stoch_pkg::HSLOT_W-1:0]   k_slot;
  logic [stoch_pkg::SEEN_W-1:0]    bars_seen;
  logic [stoch_pkg::KP_W-1:0]      scan_cnt;
  logic                            rd_pend;
  logic                            rd_first;
  logic signed [PW-1:0]            hh;
  logic signed [PW-1:0]            ll;
  logic                            k_valid;
  logic                            d_valid;
  logic [stoch_pkg::PCT_W-1:0]     pk;
  logic [stoch_pkg::PCT_W-1:0]     pd;
  logic [stoch_pkg::SUM_W-1:0]     sum;
  logic [stoch_pkg::DP_W-1:0]      d_cnt;

  logic [stoch_pkg::KP_W-1:0]      kp;
  logic [stoch_pkg::DP_W-1:0]      dp;
  logic [stoch_pkg::SLOT_W-1:0]    slot_eff;
  logic [stoch_pkg::HSLOT_W-1:0]   kslot_eff;
  logic [stoch_pkg::SEEN_W-1:0]    seen_eff;
  logic [stoch_pkg::SEEN_W-1:0]    seen_inc;
  logic [stoch_pkg::SLOT_W-1:0]    rd_addr;
  logic [stoch_pkg::RNG_W-1:0]     range;
  logic [stoch_pkg::RNG_W-1:0]     num;
  logic [stoch_pkg::PROD_W-1:0]    prod;
  logic                            d_ready;
  logic                            out_free;
  logic                            div_start;
  stoch_pkg::div_req_t             div_req;
  logic                            div_done;
  logic [stoch_pkg::DIV_BITS-1:0]  div_quo;

  // out-of-range lengths clamp to 1..max
  assign kp = (k_period == '0) ? stoch_pkg::KP_W'(1) :
              (k_period > stoch_pkg::KP_W'(stoch_pkg::MAX_K_PERIOD)) ?
              stoch_pkg::KP_W'(stoch_pkg::MAX_K_PERIOD) : k_period;
  assign dp = (d_period == '0) ? stoch_pkg::DP_W'(1) :
              (d_period > stoch_pkg::DP_W'(stoch_pkg::MAX_D_PERIOD)) ?
              stoch_pkg::DP_W'(stoch_pkg::MAX_D_PERIOD) : d_period;

  assign slot_eff  = bar.first_bar ? '0 : bar_slot;
  assign kslot_eff = bar.first_bar ? '0 : k_slot;
  assign seen_eff  = bar.first_bar ? '0 : bars_seen;
  assign seen_inc  = (seen_eff < stoch_pkg::SEEN_W'(stoch_pkg::SEEN_MAX)) ?
                     seen_eff + stoch_pkg::SEEN_W'(1) : seen_eff;

  assign rd_addr = bar_slot - scan_cnt[stoch_pkg::SLOT_W-1:0];
  assign range   = {hh[PW-1], hh} - {ll[PW-1], ll};
  assign num     = {bar.bar_close[PW-1], bar.bar_close} - {ll[PW-1], ll};
  assign prod    = stoch_pkg::PROD_W'(num) * stoch_pkg::PROD_W'(100);
  assign d_ready = ({1'b0, bars_seen} >=
                    ({1'b0, kp} + {3'b000, dp} - 8'd1));
  assign out_free = !out_valid || out_ready;
  assign q_ready  = (state == stoch_pkg::ST_IDLE);

  // the ratio lies in (0,100), so a >> 7 is already below the range
  always_comb begin
    div_start = 1'b0;
    div_req   = '0;
    if (state == stoch_pkg::ST_RATIO && hh > ll && bar.bar_close > ll &&
        bar.bar_close < hh) begin
      div_start        = 1'b1;
      div_req.rem_init = stoch_pkg::REM_W'(prod[stoch_pkg::PROD_W-1:7]);
      div_req.bits     = {prod[6:0], 20'd0};
      div_req.count    = stoch_pkg::DCNT_W'(stoch_pkg::K_QUO_BITS);
      div_req.divisor  = stoch_pkg::REM_W'(range);
    end else if (state == stoch_pkg::ST_SUM && d_cnt == dp) begin
      div_start        = 1'b1;
      div_req.rem_init = '0;
      div_req.bits     = sum;
      div_req.count    = stoch_pkg::DCNT_W'(stoch_pkg::DIV_BITS);
      div_req.divisor  = stoch_pkg::REM_W'(dp);
    end
  end

  stoch_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // window memories
  always_ff @(posedge clk) begin
    if (state == stoch_pkg::ST_WRITE) begin
      high_mem[slot_eff] <= bar.bar_high;
      low_mem[slot_eff]  <= bar.bar_low;
    end
    high_q <= high_mem[rd_addr];
    low_q  <= low_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stoch_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      stoch_pkg::ST_IDLE: begin
        if (q_valid) state_next = stoch_pkg::ST_WRITE;
      end
      stoch_pkg::ST_WRITE: begin
        state_next = (seen_inc >= kp) ? stoch_pkg::ST_SCAN : stoch_pkg::ST_KSTORE;
      end
      stoch_pkg::ST_SCAN: begin
        if (scan_cnt == kp && !rd_pend) state_next = stoch_pkg::ST_RATIO;
      end
      stoch_pkg::ST_RATIO: begin
        state_next = div_start ? stoch_pkg::ST_KDIV : stoch_pkg::ST_KSTORE;
      end
      stoch_pkg::ST_KDIV: begin
        if (div_done) state_next = stoch_pkg::ST_KSTORE;
      end
      stoch_pkg::ST_KSTORE: begin
        state_next = d_ready ? stoch_pkg::ST_SUM : stoch_pkg::ST_OUT;
      end
      stoch_pkg::ST_SUM: begin
        if (d_cnt == dp) state_next = stoch_pkg::ST_DDIV;
      end
      stoch_pkg::ST_DDIV: begin
        if (div_done) state_next = stoch_pkg::ST_OUT;
      end
      stoch_pkg::ST_OUT: begin
        if (out_free) state_next = stoch_pkg::ST_IDLE;
      end
      default: state_next = stoch_pkg::ST_IDLE;
    endcase
  end

  // series counters
  always_ff @(posedge clk) begin
    if (rst) begin
      bar_slot  <= '0;
      k_slot    <= '0;
      bars_seen <= '0;
    end else begin
      if (state == stoch_pkg::ST_WRITE) begin
        bar_slot  <= slot_eff;
        k_slot    <= kslot_eff;
        bars_seen <= seen_inc;
      end
      if (state == stoch_pkg::ST_KSTORE) begin
        bar_slot <= bar_slot + stoch_pkg::SLOT_W'(1);
        if (!d_ready) k_slot <= k_slot + stoch_pkg::HSLOT_W'(1);
      end
      if (state == stoch_pkg::ST_DDIV && div_done) begin
        k_slot <= k_slot + stoch_pkg::HSLOT_W'(1);
      end
    end
  end

  // per-item datapath
  always_ff @(posedge clk) begin
    if (state == stoch_pkg::ST_IDLE && q_valid) begin
      bar <= q_data;
    end
    if (state == stoch_pkg::ST_WRITE) begin
      scan_cnt <= '0;
      k_valid  <= 1'b0;
      pk       <= '0;
    end
    if (state == stoch_pkg::ST_SCAN) begin
      rd_pend  <= (scan_cnt < kp);
      rd_first <= (scan_cnt == '0);
      if (scan_cnt < kp) scan_cnt <= scan_cnt + stoch_pkg::KP_W'(1);
      if (rd_pend) begin
        if (rd_first || high_q > hh) hh <= high_q;
        if (rd_first || low_q < ll) ll <= low_q;
      end
    end else begin
      rd_pend <= 1'b0;
    end
    if (state == stoch_pkg::ST_RATIO) begin
      k_valid <= 1'b1;
      if (!(hh > ll)) begin
        pk <= stoch_pkg::PCT_HALF;
      end else if (bar.bar_close <= ll) begin
        pk <= '0;
      end else if (bar.bar_close >= hh) begin
        pk <= stoch_pkg::PCT_SCALE;
      end
    end
    if (state == stoch_pkg::ST_KDIV && div_done) begin
      pk <= div_quo[stoch_pkg::PCT_W-1:0];
    end
    if (state == stoch_pkg::ST_KSTORE) begin
      hist[k_slot] <= pk;
      sum          <= '0;
      d_cnt        <= '0;
      d_valid      <= d_ready;
      pd           <= '0;
    end
    if (state == stoch_pkg::ST_SUM && d_cnt != dp) begin
      sum   <= sum + stoch_pkg::SUM_W'(hist[k_slot - d_cnt[stoch_pkg::HSLOT_W-1:0]]);
      d_cnt <= d_cnt + stoch_pkg::DP_W'(1);
    end
    if (state == stoch_pkg::ST_DDIV && div_done) begin
      pd <= div_quo[stoch_pkg::PCT_W-1:0];
    end
    if (state == stoch_pkg::ST_OUT && out_free) begin
      out_data.k_valid   <= k_valid;
      out_data.percent_k <= pk;
      out_data.d_valid   <= d_valid;
      out_data.percent_d <= pd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == stoch_pkg::ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ tb/tb_stochastic_oscillator_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stochastic_oscillator_core
// Drives price bars through the oscillator with random handshake gaps, runs a
// bit-exact %K/%D predictor beside it and compares every result field.
// ----------------------------------------------------------------------------
module tb_stochastic_oscillator_core;

  logic                             clk;
  logic                             rst;
  logic                             cfg_we;
  logic [stoch_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [stoch_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                             in_valid;
  logic                             in_ready;
  stoch_pkg::bar_t                  in_data;
  logic                             out_valid;
  logic                             out_ready;
  stoch_pkg::result_t               out_data;

  stochastic_oscillator_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [stoch_pkg::KP_W-1:0]           kp_reg;
  logic [stoch_pkg::DP_W-1:0]           dp_reg;
  logic signed [stoch_pkg::PRICE_W-1:0] hi_win [stoch_pkg::MAX_K_PERIOD];
  logic signed [stoch_pkg::PRICE_W-1:0] lo_win [stoch_pkg::MAX_K_PERIOD];
  logic [stoch_pkg::PCT_W-1:0]          k_hist [stoch_pkg::MAX_D_PERIOD];
  int unsigned                          win_slot, hist_slot, seen_cnt;

  stoch_pkg::result_t expected_results[$];
  int          errors;
  int          results_seen;
  int          k_seen, d_seen;
  logic        quiet;
  logic        rx_quiet;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on %s: got %0d expected %0d (result %0d)", what, got, want,
             results_seen);
    errors++;
  endtask

  function automatic stoch_pkg::result_t predict_oscillator(input stoch_pkg::bar_t b);
    stoch_pkg::result_t r;
    int unsigned kp, dp, s, i;
    longint hh, ll, cl, num, rng, q, rem;
    longint unsigned sum;
    kp = (kp_reg < 1) ? 1 : (kp_reg > stoch_pkg::MAX_K_PERIOD) ?
         stoch_pkg::MAX_K_PERIOD : kp_reg;
    dp = (dp_reg < 1) ? 1 : (dp_reg > stoch_pkg::MAX_D_PERIOD) ?
         stoch_pkg::MAX_D_PERIOD : dp_reg;
    r = '0;
    if (b.first_bar) begin
      win_slot = 0; hist_slot = 0; seen_cnt = 0;
    end
    hi_win[win_slot] = b.bar_high;
    lo_win[win_slot] = b.bar_low;
    if (seen_cnt < stoch_pkg::SEEN_MAX) seen_cnt++;
    if (seen_cnt >= kp) begin
      r.k_valid = 1'b1;
      for (i = 0; i < kp; i++) begin
        s = (win_slot + stoch_pkg::MAX_K_PERIOD - i) % stoch_pkg::MAX_K_PERIOD;
        if (i == 0 || hi_win[s] > hh) hh = hi_win[s];
        if (i == 0 || lo_win[s] < ll) ll = lo_win[s];
      end
      cl = b.bar_close;
      if (hh > ll) begin
        if (cl <= ll) r.percent_k = '0;
        else if (cl >= hh) r.percent_k = stoch_pkg::PCT_SCALE;
        else begin
          num = (cl - ll) * 100;
          rng = hh - ll;
          q = num / rng;
          rem = num % rng;
          for (i = 0; i < 16; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= rng) begin
              rem -= rng;
              q |= 1;
            end
          end
          r.percent_k = q[stoch_pkg::PCT_W-1:0];
        end
      end else begin
        r.percent_k = stoch_pkg::PCT_HALF;
      end
    end
    win_slot = (win_slot + 1) % stoch_pkg::MAX_K_PERIOD;
    k_hist[hist_slot] = r.percent_k;
    if (seen_cnt >= kp + dp - 1) begin
      r.d_valid = 1'b1;
      sum = 0;
      for (i = 0; i < dp; i++)
        sum += k_hist[(hist_slot + stoch_pkg::MAX_D_PERIOD - i) % stoch_pkg::MAX_D_PERIOD];
      r.percent_d = stoch_pkg::PCT_W'(sum / dp);
    end
    hist_slot = (hist_slot + 1) % stoch_pkg::MAX_D_PERIOD;
    return r;
  endfunction

  task automatic write_reg(input logic [stoch_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= stoch_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == stoch_pkg::CFG_K_PERIOD) kp_reg = stoch_pkg::KP_W'(val);
    else dp_reg = stoch_pkg::DP_W'(val);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // sends one bar; optional typed-in result checked on top of the predictor
  // valid stays high after acceptance until the next request or an idle cycle
  task automatic send_bar(input stoch_pkg::bar_t b, input logic has_known,
                          input stoch_pkg::result_t known);
    stoch_pkg::result_t r;
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    r = predict_oscillator(b);
    if (has_known && r !== known)
      report_mismatch("directed row", r.percent_k, known.percent_k);
    expected_results.push_back(r);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receive side
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          stoch_pkg::result_t w;
          w = expected_results.pop_front();
          if (out_data.k_valid !== w.k_valid)
            report_mismatch("k_valid", out_data.k_valid, w.k_valid);
          if (out_data.percent_k !== w.percent_k)
            report_mismatch("percent_k", out_data.percent_k, w.percent_k);
          if (out_data.d_valid !== w.d_valid)
            report_mismatch("d_valid", out_data.d_valid, w.d_valid);
          if (out_data.percent_d !== w.percent_d)
            report_mismatch("percent_d", out_data.percent_d, w.percent_d);
          if (w.k_valid) k_seen++;
          if (w.d_valid) d_seen++;
        end
        results_seen++;
      end
      out_ready <= rx_quiet ? 1'b1 : ($urandom_range(99) >= 10);
    end
  end

  typedef struct {
    stoch_pkg::bar_t    b;
    logic               has_known;
    stoch_pkg::result_t known;
  } row_t;

  function automatic stoch_pkg::bar_t rand_bar(input logic first, input int signed base,
                                               input int unsigned spread);
    stoch_pkg::bar_t b;
    int signed lo, hi;
    lo = base - int'($urandom_range(spread));
    hi = base + int'($urandom_range(spread));
    b.first_bar = first;
    b.bar_high  = hi;
    b.bar_low   = lo;
    case ($urandom_range(9))
      0: b.bar_close = lo - int'($urandom_range(spread));
      1: b.bar_close = hi + int'($urandom_range(spread));
      2: b.bar_close = $urandom;
      default: b.bar_close = lo + int'($urandom_range(hi - lo));
    endcase
    return b;
  endfunction

  initial begin : stimulus
    row_t rows[$];
    row_t rw;
    stoch_pkg::result_t nk;
    int signed base;
    int n, j, len;
    int kp_set[6];
    int dp_set[6];
    rst = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    quiet = 1'b0; rx_quiet = 1'b0;
    errors = 0; results_seen = 0; k_seen = 0; d_seen = 0;
    kp_reg = 14; dp_reg = 3; win_slot = 0; hist_slot = 0; seen_cnt = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: k=1, d=1 so results are readable at a glance
    write_reg(stoch_pkg::CFG_K_PERIOD, 1);
    write_reg(stoch_pkg::CFG_D_PERIOD, 1);
    nk = '0; nk.k_valid = 1; nk.d_valid = 1;
    rw.has_known = 1'b1;
    // flat bar
    rw.b = '{1'b1, 32'sd100, 32'sd100, 32'sd100};
    rw.known = nk;
    rw.known.percent_k = stoch_pkg::PCT_HALF;
    rw.known.percent_d = stoch_pkg::PCT_HALF;
    rows.push_back(rw);
    // close at low
    rw.b = '{1'b0, 32'h7fffffff, 32'h80000000, 32'h80000000};
    rw.known = nk; rows.push_back(rw);
    // close at high, full-scale extremes
    rw.b = '{1'b0, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
    rw.known = nk;
    rw.known.percent_k = stoch_pkg::PCT_SCALE;
    rw.known.percent_d = stoch_pkg::PCT_SCALE;
    rows.push_back(rw);
    // inverted range
    rw.b = '{1'b0, -32'sd5, 32'sd5, 32'sd0};
    rw.known = nk;
    rw.known.percent_k = stoch_pkg::PCT_HALF;
    rw.known.percent_d = stoch_pkg::PCT_HALF;
    rows.push_back(rw);
    // midpoint and near-edge ratios, predictor only
    rw.has_known = 1'b0;
    rw.b = '{1'b0, 32'h7fffffff, 32'h80000000, 32'sd0}; rows.push_back(rw);
    rw.b = '{1'b0, 32'sd3, 32'sd0, 32'sd1}; rows.push_back(rw);
    rw.b = '{1'b0, 32'h7fffffff, 32'h80000000, 32'h7ffffffe}; rows.push_back(rw);
    rw.b = '{1'b0, -32'sd1, 32'h80000000, 32'h80000001}; rows.push_back(rw);
    foreach (rows[i]) send_bar(rows[i].b, rows[i].has_known, rows[i].known);
    wait_drained();

    // out-of-range register values: 0 and above max clamp
    write_reg(stoch_pkg::CFG_K_PERIOD, 0);
    write_reg(stoch_pkg::CFG_D_PERIOD, 0);
    send_bar('{1'b1, 32'sd10, 32'sd0, 32'sd5}, 1'b0, nk);
    send_bar('{1'b0, 32'sd20, -32'sd10, 32'sd5}, 1'b0, nk);
    wait_drained();
    write_reg(stoch_pkg::CFG_K_PERIOD, 127);
    write_reg(stoch_pkg::CFG_D_PERIOD, 31);
    for (j = 0; j < 8; j++) send_bar(rand_bar(j == 0, 0, 1000), 1'b0, nk);
    wait_drained();

    // random series over several settings, extremes included
    kp_set = '{1, 64, 14, 3, 7, 64};
    dp_set = '{16, 1, 3, 2, 16, 16};
    n = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(stoch_pkg::CFG_K_PERIOD, kp_set[ph]);
      write_reg(stoch_pkg::CFG_D_PERIOD, dp_set[ph]);
      quiet = (ph == 2);
      rx_quiet = (ph == 2);
      // first bar of a phase always starts a series
      j = 0;
      while (j < 170) begin
        len = $urandom_range(5, 100);
        base = int'($urandom) >>> $urandom_range(0, 12);
        for (int b = 0; b < len && j < 170; b++) begin
          send_bar(rand_bar(b == 0, base, $urandom_range(1) ? 1 << $urandom_range(20) : 3),
                   1'b0, nk);
          base += int'($urandom_range(2000)) - 1000;
          j++; n++;
        end
        // occasionally wait for every result before the next series
        if ($urandom_range(3) == 0) begin
          in_valid <= 1'b0;
          while (expected_results.size() != 0) @(posedge clk);
        end
      end
      // register change inside a running series
      if (ph == 3) begin
        wait_drained();
        write_reg(stoch_pkg::CFG_K_PERIOD, 5);
        for (j = 0; j < 10; j++) send_bar(rand_bar(1'b0, 0, 5000), 1'b0, nk);
      end
      wait_drained();
    end
    quiet = 1'b0;
    rx_quiet = 1'b0;

    wait_drained();
    $display("ran %0d random bars after the directed rows, %0d results checked", n,
             results_seen);
    $display("%0d with valid %%K, %0d with valid %%D, k_period and d_period swept", k_seen,
             d_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
